[hw/rtl/jst_pkg.sv]
// jst_pkg: shared types, codes and sizes for the json stream tokenizer
// used by jst_front, jst_back and json_stream_tokenizer
package jst_pkg;

  localparam int MaxNest = 32;
  localparam int DepthW  = $clog2(MaxNest + 1);
  localparam int IdxW    = $clog2(MaxNest);
  localparam int PosW    = 32;
  localparam int OutPosW = 32;
  localparam int QDepth  = 4;
  localparam int QIdxW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);
  localparam int MaxRes  = 3;

  localparam logic [1:0] EV_OPEN  = 2'd0;
  localparam logic [1:0] EV_CLOSE = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  localparam logic [2:0] VK_STRING = 3'd0;
  localparam logic [2:0] VK_NUMBER = 3'd1;
  localparam logic [2:0] VK_TRUE   = 3'd2;
  localparam logic [2:0] VK_FALSE  = 3'd3;
  localparam logic [2:0] VK_NULL   = 3'd4;
  localparam logic [2:0] VK_OBJECT = 3'd5;
  localparam logic [2:0] VK_ARRAY  = 3'd6;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_BYTE  = 2'd1;
  localparam logic [1:0] ERR_SHORT = 2'd2;
  localparam logic [1:0] ERR_DEEP  = 2'd3;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [2:0]         value_kind;
    logic               is_key;
    logic [5:0]         nest_depth;
    logic [OutPosW-1:0] span_start;
    logic [OutPosW-1:0] span_end;
    logic [1:0]         error_code;
    logic               run_last;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t [MaxRes-1:0] r;
  } grp_t;

  typedef struct packed {
    logic valid;
    grp_t grp;
  } grp_push_t;

endpackage

[hw/rtl/jst_if.sv]
// jst_if: valid/ready channel interfaces for input bytes and result beats
// needs no package: the offset width is written out as 32 bits
interface jst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;
  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface jst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [2:0]  value_kind;
  logic        is_key;
  logic [5:0]  nest_depth;
  logic [31:0] span_start;
  logic [31:0] span_end;
  logic [1:0]  error_code;
  logic        run_last;
  modport source (output valid, output event_kind, output value_kind, output is_key,
                  output nest_depth, output span_start, output span_end,
                  output error_code, output run_last, input ready);
  modport sink (input valid, input event_kind, input value_kind, input is_key,
                input nest_depth, input span_start, input span_end,
                input error_code, input run_last, output ready);
endinterface

[hw/rtl/jst_front.sv]
// jst_front: byte classifier, grammar state machine and container stack
// depends on jst_pkg and jst_in_if; pushes result groups to jst_back
module jst_front (
  input  logic                clk,
  input  logic                rst_n,
  jst_in_if.sink              in_ch,
  input  logic                q_full,
  output jst_pkg::grp_push_t  push
);
  import jst_pkg::*;

  typedef enum logic [32:0] {
    PH_ROOT   = 33'd1 << 0,  PH_AFIRST = 33'd1 << 1,  PH_VALUE = 33'd1 << 2,
    PH_T2     = 33'd1 << 3,  PH_T3     = 33'd1 << 4,  PH_T4    = 33'd1 << 5,
    PH_F2     = 33'd1 << 6,  PH_F3     = 33'd1 << 7,  PH_F4    = 33'd1 << 8,
    PH_F5     = 33'd1 << 9,  PH_X2     = 33'd1 << 10, PH_X3    = 33'd1 << 11,
    PH_X4     = 33'd1 << 12, PH_S2     = 33'd1 << 13, PH_S3    = 33'd1 << 14,
    PH_S4     = 33'd1 << 15, PH_S5     = 33'd1 << 16, PH_S6    = 33'd1 << 17,
    PH_S7     = 33'd1 << 18, PH_N2     = 33'd1 << 19, PH_N3    = 33'd1 << 20,
    PH_N4     = 33'd1 << 21, PH_N5     = 33'd1 << 22, PH_N6    = 33'd1 << 23,
    PH_N7     = 33'd1 << 24, PH_N8     = 33'd1 << 25, PH_N9    = 33'd1 << 26,
    PH_O2     = 33'd1 << 27, PH_O3     = 33'd1 << 28, PH_O5    = 33'd1 << 29,
    PH_O6     = 33'd1 << 30, PH_A3     = 33'd1 << 31, PH_DONE  = 33'd1 << 32
  } ph_t;

  typedef struct packed {
    ph_t              phase;
    logic [DepthW-1:0] depth;
    logic [PosW-1:0]  sstart;
    logic             skey;
  } pst_t;

  typedef struct packed {
    pst_t st;
    logic err;
    logic rv;
    res_t r;
    logic again;
    logic push;
    logic push_kind;
    logic pop;
  } hres_t;

  function automatic logic is_ws(logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0a || b == 8'h0d;
  endfunction

  function automatic logic is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_hex(logic [7:0] b);
    return is_dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic ph_t after_value(logic key, logic [DepthW-1:0] d, logic ktop);
    if (d == '0) return PH_DONE;
    if (!ktop) return key ? PH_O3 : PH_O5;
    return PH_A3;
  endfunction

  function automatic hres_t do_fail(hres_t hi, logic [1:0] code, logic [PosW-1:0] p);
    hres_t h;
    h = hi;
    h.err = 1'b1;
    h.rv = 1'b1;
    h.r = '0;
    h.r.event_kind = EV_ERROR;
    h.r.span_start = OutPosW'(p);
    h.r.error_code = code;
    return h;
  endfunction

  function automatic hres_t do_expect(hres_t hi, logic ok, ph_t nxt, logic [PosW-1:0] p);
    hres_t h;
    h = hi;
    if (ok) h.st.phase = nxt;
    else h = do_fail(h, ERR_BYTE, p);
    return h;
  endfunction

  function automatic hres_t open_scalar(hres_t hi, logic [2:0] kind, ph_t nxt, logic key,
                                        logic [PosW-1:0] p);
    hres_t h;
    h = hi;
    h.st.sstart = p;
    h.st.skey = key;
    h.rv = 1'b1;
    h.r = '0;
    h.r.event_kind = EV_OPEN;
    h.r.value_kind = kind;
    h.r.is_key = key;
    h.r.nest_depth = 6'(h.st.depth);
    h.r.span_start = OutPosW'(p);
    h.st.phase = nxt;
    return h;
  endfunction

  function automatic hres_t close_scalar(hres_t hi, logic [2:0] kind, logic [PosW-1:0] s,
                                         logic [PosW-1:0] e, logic k0);
    hres_t h;
    h = hi;
    h.rv = 1'b1;
    h.r = '0;
    h.r.event_kind = EV_CLOSE;
    h.r.value_kind = kind;
    h.r.is_key = h.st.skey;
    h.r.nest_depth = 6'(h.st.depth);
    h.r.span_start = OutPosW'(s);
    h.r.span_end = OutPosW'(e);
    h.st.phase = after_value(h.st.skey, h.st.depth, k0);
    h.st.skey = 1'b0;
    return h;
  endfunction

  function automatic hres_t open_cont(hres_t hi, logic arr, logic [PosW-1:0] p);
    hres_t h;
    h = hi;
    if (h.st.depth == DepthW'(MaxNest)) begin
      h = do_fail(h, ERR_DEEP, p);
    end else begin
      h.rv = 1'b1;
      h.r = '0;
      h.r.event_kind = EV_OPEN;
      h.r.value_kind = arr ? VK_ARRAY : VK_OBJECT;
      h.r.nest_depth = 6'(h.st.depth);
      h.r.span_start = OutPosW'(p);
      h.push = 1'b1;
      h.push_kind = arr;
      h.st.depth = h.st.depth + 1'b1;
      h.st.phase = arr ? PH_AFIRST : PH_O2;
    end
    return h;
  endfunction

  function automatic hres_t close_cont(hres_t hi, logic k0, logic k1, logic [PosW-1:0] ts,
                                       logic [PosW-1:0] p);
    hres_t h;
    h = hi;
    if (h.st.depth == '0) begin
      h = do_fail(h, ERR_BYTE, p);
    end else begin
      h.st.depth = h.st.depth - 1'b1;
      h.rv = 1'b1;
      h.r = '0;
      h.r.event_kind = EV_CLOSE;
      h.r.value_kind = k0 ? VK_ARRAY : VK_OBJECT;
      h.r.nest_depth = 6'(h.st.depth);
      h.r.span_start = OutPosW'(ts);
      h.r.span_end = OutPosW'(p + 1'b1);
      h.pop = 1'b1;
      h.st.phase = after_value(1'b0, h.st.depth, k1);
    end
    return h;
  endfunction

  // one pass of the grammar over a byte; again flags a byte that ended a number
  function automatic hres_t handle(pst_t s, logic [7:0] b, logic k0, logic k1,
                                   logic [PosW-1:0] ts, logic [PosW-1:0] p);
    hres_t h;
    h = '0;
    h.st = s;
    unique case (s.phase)
      PH_ROOT, PH_AFIRST, PH_VALUE: begin
        if (b == "t") h = open_scalar(h, VK_TRUE, PH_T2, 1'b0, p);
        else if (b == "f") h = open_scalar(h, VK_FALSE, PH_F2, 1'b0, p);
        else if (b == "n") h = open_scalar(h, VK_NULL, PH_X2, 1'b0, p);
        else if (b == "\"") h = open_scalar(h, VK_STRING, PH_S2, 1'b0, p);
        else if (b == "-") h = open_scalar(h, VK_NUMBER, PH_N2, 1'b0, p);
        else if (b == "0") h = open_scalar(h, VK_NUMBER, PH_N6, 1'b0, p);
        else if (is_dig(b)) h = open_scalar(h, VK_NUMBER, PH_N3, 1'b0, p);
        else if (b == "{") h = open_cont(h, 1'b0, p);
        else if (b == "[") h = open_cont(h, 1'b1, p);
        else if (is_ws(b)) h = h;
        else if (s.phase == PH_AFIRST && b == "]") h = close_cont(h, k0, k1, ts, p);
        else h = do_fail(h, ERR_BYTE, p);
      end
      PH_T2: h = do_expect(h, b == "r", PH_T3, p);
      PH_T3: h = do_expect(h, b == "u", PH_T4, p);
      PH_T4: begin
        if (b == "e") h = close_scalar(h, VK_TRUE, s.sstart, p + 1'b1, k0);
        else h = do_fail(h, ERR_BYTE, p);
      end
      PH_F2: h = do_expect(h, b == "a", PH_F3, p);
      PH_F3: h = do_expect(h, b == "l", PH_F4, p);
      PH_F4: h = do_expect(h, b == "s", PH_F5, p);
      PH_F5: begin
        if (b == "e") h = close_scalar(h, VK_FALSE, s.sstart, p + 1'b1, k0);
        else h = do_fail(h, ERR_BYTE, p);
      end
      PH_X2: h = do_expect(h, b == "u", PH_X3, p);
      PH_X3: h = do_expect(h, b == "l", PH_X4, p);
      PH_X4: begin
        if (b == "l") h = close_scalar(h, VK_NULL, s.sstart, p + 1'b1, k0);
        else h = do_fail(h, ERR_BYTE, p);
      end
      PH_S2: begin
        if (b == "\"") h = close_scalar(h, VK_STRING, s.sstart + 1'b1, p, k0);
        else if (b == "\\") h.st.phase = PH_S3;
        else if (b < 8'd32) h = do_fail(h, ERR_BYTE, p);
      end
      PH_S3: begin
        if (b == "\"" || b == "f" || b == "/" || b == "b" || b == "n" ||
            b == "r" || b == "t" || b == "\\") h.st.phase = PH_S2;
        else if (b == "u") h.st.phase = PH_S4;
        else h = do_fail(h, ERR_BYTE, p);
      end
      PH_S4: h = do_expect(h, is_hex(b), PH_S5, p);
      PH_S5: h = do_expect(h, is_hex(b), PH_S6, p);
      PH_S6: h = do_expect(h, is_hex(b), PH_S7, p);
      PH_S7: h = do_expect(h, is_hex(b), PH_S2, p);
      PH_N2: begin
        if (b == "0") h.st.phase = PH_N6;
        else h = do_expect(h, is_dig(b), PH_N3, p);
      end
      PH_N4: h = do_expect(h, is_dig(b), PH_N5, p);
      PH_N7: begin
        if (b == "+" || b == "-") h.st.phase = PH_N8;
        else h = do_expect(h, is_dig(b), PH_N9, p);
      end
      PH_N8: h = do_expect(h, is_dig(b), PH_N9, p);
      PH_N3, PH_N5, PH_N6, PH_N9: begin
        if (b == "." && (s.phase == PH_N3 || s.phase == PH_N6)) h.st.phase = PH_N4;
        else if ((b == "e" || b == "E") && s.phase != PH_N9) h.st.phase = PH_N7;
        else if (is_dig(b) && s.phase != PH_N6) h = h;
        else begin
          h = close_scalar(h, VK_NUMBER, s.sstart, p, k0);
          h.again = 1'b1;
        end
      end
      PH_O2: begin
        if (b == "\"") h = open_scalar(h, VK_STRING, PH_S2, 1'b1, p);
        else if (b == "}") h = close_cont(h, k0, k1, ts, p);
        else if (!is_ws(b)) h = do_fail(h, ERR_BYTE, p);
      end
      PH_O3: begin
        if (b == ":") h.st.phase = PH_VALUE;
        else if (!is_ws(b)) h = do_fail(h, ERR_BYTE, p);
      end
      PH_O5: begin
        if (b == ",") h.st.phase = PH_O6;
        else if (b == "}") h = close_cont(h, k0, k1, ts, p);
        else if (!is_ws(b)) h = do_fail(h, ERR_BYTE, p);
      end
      PH_O6: begin
        if (b == "\"") h = open_scalar(h, VK_STRING, PH_S2, 1'b1, p);
        else if (!is_ws(b)) h = do_fail(h, ERR_BYTE, p);
      end
      PH_A3: begin
        if (b == ",") h.st.phase = PH_VALUE;
        else if (b == "]") h = close_cont(h, k0, k1, ts, p);
        else if (!is_ws(b)) h = do_fail(h, ERR_BYTE, p);
      end
      PH_DONE: begin
        if (!is_ws(b)) h = do_fail(h, ERR_BYTE, p);
      end
      default: h = do_fail(h, ERR_BYTE, p);
    endcase
    return h;
  endfunction

  pst_t                st_r, st_nxt;
  logic                err_r, err_nxt;
  logic [PosW-1:0]     pos_r, pos_nxt;
  logic [MaxNest-1:0]  kinds_r, kinds_nxt;   // bit 0 is the innermost container
  logic [PosW-1:0]     starts_r [MaxNest];
  logic [PosW-1:0]     top_start;
  logic [DepthW-1:0]   top_dep;
  hres_t               h1, h2;
  pst_t                sp;
  logic                perr;
  logic                do_push, do_pop, push_kind;
  logic [PosW-1:0]     len;
  res_t [MaxRes-1:0]   rs;
  logic [1:0]          n;
  logic                accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;
  assign top_dep = st_r.depth - 1'b1;
  assign top_start = starts_r[top_dep[IdxW-1:0]];

  always_comb begin
    h1 = handle(st_r, in_ch.text_byte, kinds_r[0], kinds_r[1], top_start, pos_r);
    h2 = handle(h1.st, in_ch.text_byte, kinds_r[0], kinds_r[1], top_start, pos_r);
    sp = st_r;
    perr = err_r;
    do_push = 1'b0;
    do_pop = 1'b0;
    push_kind = 1'b0;
    rs = '0;
    n = '0;
    len = pos_r + 1'b1;
    if (!err_r) begin
      sp = h1.st;
      perr = h1.err;
      do_push = h1.push;
      push_kind = h1.push_kind;
      do_pop = h1.pop;
      if (h1.rv) begin
        rs[n] = h1.r;
        n = n + 1'b1;
      end
      // the byte that ended a number goes through the grammar once more
      if (h1.again && !h1.err) begin
        sp = h2.st;
        perr = h2.err;
        do_pop = h2.pop;
        if (h2.rv) begin
          rs[n] = h2.r;
          n = n + 1'b1;
        end
      end
    end
    if (in_ch.last_byte && !perr) begin
      if ((sp.phase == PH_N3 || sp.phase == PH_N5 || sp.phase == PH_N6 ||
           sp.phase == PH_N9) && sp.depth == '0) begin
        rs[n] = '0;
        rs[n].event_kind = EV_CLOSE;
        rs[n].value_kind = VK_NUMBER;
        rs[n].is_key = sp.skey;
        rs[n].span_start = OutPosW'(sp.sstart);
        rs[n].span_end = OutPosW'(len);
        n = n + 1'b1;
        rs[n] = '0;
        rs[n].event_kind = EV_END;
        rs[n].span_end = OutPosW'(len);
        n = n + 1'b1;
      end else if (sp.phase == PH_DONE) begin
        rs[n] = '0;
        rs[n].event_kind = EV_END;
        rs[n].span_end = OutPosW'(len);
        n = n + 1'b1;
      end else begin
        rs[n] = '0;
        rs[n].event_kind = EV_ERROR;
        rs[n].span_start = OutPosW'(len);
        rs[n].error_code = ERR_SHORT;
        n = n + 1'b1;
      end
    end
    if (n != '0) rs[n - 1'b1].run_last = 1'b1;

    kinds_nxt = kinds_r;
    if (do_push) kinds_nxt = {kinds_r[MaxNest-2:0], push_kind};
    else if (do_pop) kinds_nxt = {1'b0, kinds_r[MaxNest-1:1]};

    if (in_ch.last_byte) begin
      st_nxt = '{phase: PH_ROOT, depth: '0, sstart: '0, skey: 1'b0};
      err_nxt = 1'b0;
      pos_nxt = '0;
    end else begin
      st_nxt = sp;
      err_nxt = perr;
      pos_nxt = pos_r + 1'b1;
    end
  end

  assign push.valid = accept && (n != '0);
  assign push.grp.cnt = n;
  assign push.grp.r = rs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_ROOT, depth: '0, sstart: '0, skey: 1'b0};
      err_r <= 1'b0;
      pos_r <= '0;
      kinds_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
      err_r <= err_nxt;
      pos_r <= pos_nxt;
      kinds_r <= kinds_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_push) starts_r[st_r.depth[IdxW-1:0]] <= pos_r;
  end

endmodule

[hw/rtl/jst_back.sv]
// jst_back: queue of per-byte result groups and the output register
// depends on jst_pkg and jst_out_if; fed by jst_front
module jst_back (
  input  logic               clk,
  input  logic               rst_n,
  input  jst_pkg::grp_push_t push,
  output logic               q_full,
  jst_out_if.source          out_ch
);
  import jst_pkg::*;

  grp_t             q_r [QDepth];
  logic [QIdxW-1:0] wp_r, rp_r;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic [1:0]       sub_r;
  logic             ov_r, ov_nxt;
  res_t             res_r;
  logic             load, pop;
  grp_t             head;

  assign head = q_r[rp_r];
  assign q_full = cnt_r == QCntW'(QDepth);
  assign load = (!ov_r || out_ch.ready) && cnt_r != '0;
  assign pop = load && (sub_r == head.cnt - 2'd1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push.valid && pop) cnt_nxt = cnt_r - 1'b1;
    if (load) ov_nxt = 1'b1;
    else if (out_ch.ready) ov_nxt = 1'b0;
    else ov_nxt = ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
      sub_r <= '0;
      ov_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      if (push.valid) wp_r <= wp_r + 1'b1;
      if (pop) begin
        rp_r <= rp_r + 1'b1;
        sub_r <= '0;
      end else if (load) begin
        sub_r <= sub_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) q_r[wp_r] <= push.grp;
    if (load) res_r <= head.r[sub_r];
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.event_kind = res_r.event_kind;
  assign out_ch.value_kind = res_r.value_kind;
  assign out_ch.is_key     = res_r.is_key;
  assign out_ch.nest_depth = res_r.nest_depth;
  assign out_ch.span_start = res_r.span_start;
  assign out_ch.span_end   = res_r.span_end;
  assign out_ch.error_code = res_r.error_code;
  assign out_ch.run_last   = res_r.run_last;

endmodule

[hw/rtl/json_stream_tokenizer.sv]
// json_stream_tokenizer: strict json validating tokenizer, top level
// depends on jst_pkg, jst_if, jst_front and jst_back
//
//  channel | dir | beat
//  in_ch   | in  | text_byte, last_byte
//  out_ch  | out | one token event or final status
//
// one byte is taken every cycle while the result queue has a free slot
// each byte gives zero to three results; the output register sends one per cycle while out_ch.ready is high
// a byte's results are written into the queue, then loaded into the output register
// the queue holds four byte groups; in_ch.ready drops when it is full
// synchronous active-low reset returns the parser to the root state
module json_stream_tokenizer (
  input  logic     clk,
  input  logic     rst_n,
  jst_in_if.sink   in_ch,
  jst_out_if.source out_ch
);
  import jst_pkg::*;

  grp_push_t push;
  logic      q_full;

  jst_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  jst_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_full (q_full),
    .out_ch (out_ch)
  );

endmodule

[tb/json_stream_tokenizer_tb.sv]
// json_stream_tokenizer_tb: self-checking bench for the json stream tokenizer
// depends on jst_pkg, jst_in_if/jst_out_if and the json_stream_tokenizer rtl
// directed texts first, then random well-formed, broken and deeply nested texts
module json_stream_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jst_pkg::*;

  typedef enum int {
    P_ROOT, P_AFIRST, P_VALUE, P_T2, P_T3, P_T4, P_F2, P_F3, P_F4, P_F5,
    P_X2, P_X3, P_X4, P_S2, P_S3, P_S4, P_S5, P_S6, P_S7,
    P_N2, P_N3, P_N4, P_N5, P_N6, P_N7, P_N8, P_N9,
    P_O2, P_O3, P_O5, P_O6, P_A3, P_DONE
  } phase_e;

  typedef struct {
    bit [7:0] b;
    bit       last;
    bit       typed;
    res_t     want;
  } row_t;

  logic clk;
  logic rst_n;
  jst_in_if  in_ch();
  jst_out_if out_ch();

  json_stream_tokenizer DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // parser state mirror
  phase_e      phase;
  bit          nest_is_array [MaxNest];
  logic [31:0] nest_start [MaxNest];
  int          nest_cnt;
  logic [31:0] tok_start;
  bit          tok_key;
  logic [31:0] offset;
  bit          failed;

  res_t        byte_events[$];
  res_t        pending_events[$];
  bit [7:0]    txt[$];
  row_t        rows[$];
  int          mismatches;
  int          cycles;
  bit          quiet;

  function automatic void clear_parser();
    phase = P_ROOT; nest_cnt = 0; tok_start = '0; tok_key = 0;
    offset = '0; failed = 0;
  endfunction

  function automatic void add_event(logic [1:0] ev, logic [2:0] vk, bit key, int depth,
                                    logic [31:0] s, logic [31:0] e, logic [1:0] code);
    res_t r;
    r.event_kind = ev; r.value_kind = vk; r.is_key = key;
    r.nest_depth = depth[5:0]; r.span_start = s; r.span_end = e;
    r.error_code = code; r.run_last = 1'b0;
    byte_events.push_back(r);
  endfunction

  function automatic void flag_error(logic [1:0] code);
    add_event(EV_ERROR, VK_STRING, 0, 0, offset, '0, code);
    failed = 1;
  endfunction

  function automatic bit is_ws(bit [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0a || b == 8'h0d;
  endfunction

  function automatic bit is_dig(bit [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_hex(bit [7:0] b);
    return is_dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic phase_e next_after_value(bit key);
    if (nest_cnt == 0) return P_DONE;
    if (!nest_is_array[nest_cnt-1]) return key ? P_O3 : P_O5;
    return P_A3;
  endfunction

  function automatic void open_token(logic [2:0] vk, phase_e nxt, bit key);
    tok_start = offset; tok_key = key;
    add_event(EV_OPEN, vk, key, nest_cnt, offset, '0, ERR_NONE);
    phase = nxt;
  endfunction

  function automatic void close_token(logic [2:0] vk, logic [31:0] s, logic [31:0] e);
    add_event(EV_CLOSE, vk, tok_key, nest_cnt, s, e, ERR_NONE);
    phase = next_after_value(tok_key);
    tok_key = 0;
  endfunction

  function automatic void open_nest(bit arr);
    if (nest_cnt >= MaxNest) begin
      flag_error(ERR_DEEP);
      return;
    end
    add_event(EV_OPEN, arr ? VK_ARRAY : VK_OBJECT, 0, nest_cnt, offset, '0, ERR_NONE);
    nest_is_array[nest_cnt] = arr;
    nest_start[nest_cnt] = offset;
    nest_cnt++;
    phase = arr ? P_AFIRST : P_O2;
  endfunction

  function automatic void close_nest();
    if (nest_cnt == 0) begin
      flag_error(ERR_BYTE);
      return;
    end
    nest_cnt--;
    add_event(EV_CLOSE, nest_is_array[nest_cnt] ? VK_ARRAY : VK_OBJECT, 0, nest_cnt,
              nest_start[nest_cnt], offset + 1, ERR_NONE);
    phase = next_after_value(0);
  endfunction

  function automatic void step_to(bit ok, phase_e nxt);
    if (ok) phase = nxt;
    else flag_error(ERR_BYTE);
  endfunction

  // returns 1 when the byte ended a number and has to be parsed again
  function automatic bit parse_byte(bit [7:0] b);
    case (phase)
      P_ROOT, P_AFIRST, P_VALUE: begin
        if (b == "t") open_token(VK_TRUE, P_T2, 0);
        else if (b == "f") open_token(VK_FALSE, P_F2, 0);
        else if (b == "n") open_token(VK_NULL, P_X2, 0);
        else if (b == "\"") open_token(VK_STRING, P_S2, 0);
        else if (b == "-") open_token(VK_NUMBER, P_N2, 0);
        else if (b == "0") open_token(VK_NUMBER, P_N6, 0);
        else if (is_dig(b)) open_token(VK_NUMBER, P_N3, 0);
        else if (b == "{") open_nest(0);
        else if (b == "[") open_nest(1);
        else if (is_ws(b)) ;
        else if (phase == P_AFIRST && b == "]") close_nest();
        else flag_error(ERR_BYTE);
      end
      P_T2: step_to(b == "r", P_T3);
      P_T3: step_to(b == "u", P_T4);
      P_T4: if (b == "e") close_token(VK_TRUE, tok_start, offset + 1); else flag_error(ERR_BYTE);
      P_F2: step_to(b == "a", P_F3);
      P_F3: step_to(b == "l", P_F4);
      P_F4: step_to(b == "s", P_F5);
      P_F5: if (b == "e") close_token(VK_FALSE, tok_start, offset + 1); else flag_error(ERR_BYTE);
      P_X2: step_to(b == "u", P_X3);
      P_X3: step_to(b == "l", P_X4);
      P_X4: if (b == "l") close_token(VK_NULL, tok_start, offset + 1); else flag_error(ERR_BYTE);
      P_S2: begin
        if (b == "\"") close_token(VK_STRING, tok_start + 1, offset);
        else if (b == "\\") phase = P_S3;
        else if (b < 8'd32) flag_error(ERR_BYTE);
      end
      P_S3: begin
        if (b == "\"" || b == "f" || b == "/" || b == "b" || b == "n" ||
            b == "r" || b == "t" || b == "\\") phase = P_S2;
        else if (b == "u") phase = P_S4;
        else flag_error(ERR_BYTE);
      end
      P_S4: step_to(is_hex(b), P_S5);
      P_S5: step_to(is_hex(b), P_S6);
      P_S6: step_to(is_hex(b), P_S7);
      P_S7: step_to(is_hex(b), P_S2);
      P_N2: if (b == "0") phase = P_N6; else step_to(is_dig(b), P_N3);
      P_N4: step_to(is_dig(b), P_N5);
      P_N7: if (b == "+" || b == "-") phase = P_N8; else step_to(is_dig(b), P_N9);
      P_N8: step_to(is_dig(b), P_N9);
      P_N3, P_N5, P_N6, P_N9: begin
        if (b == "." && (phase == P_N3 || phase == P_N6)) phase = P_N4;
        else if ((b == "e" || b == "E") && phase != P_N9) phase = P_N7;
        else if (is_dig(b) && phase != P_N6) ;
        else begin
          close_token(VK_NUMBER, tok_start, offset);
          return 1;
        end
      end
      P_O2: begin
        if (b == "\"") open_token(VK_STRING, P_S2, 1);
        else if (b == "}") close_nest();
        else if (!is_ws(b)) flag_error(ERR_BYTE);
      end
      P_O3: if (b == ":") phase = P_VALUE; else if (!is_ws(b)) flag_error(ERR_BYTE);
      P_O5: begin
        if (b == ",") phase = P_O6;
        else if (b == "}") close_nest();
        else if (!is_ws(b)) flag_error(ERR_BYTE);
      end
      P_O6: if (b == "\"") open_token(VK_STRING, P_S2, 1); else if (!is_ws(b)) flag_error(ERR_BYTE);
      P_A3: begin
        if (b == ",") phase = P_VALUE;
        else if (b == "]") close_nest();
        else if (!is_ws(b)) flag_error(ERR_BYTE);
      end
      default: if (!is_ws(b)) flag_error(ERR_BYTE);
    endcase
    return 0;
  endfunction

  // events caused by one accepted beat, left in byte_events
  function automatic void predict_events(bit [7:0] b, bit last);
    logic [31:0] len;
    byte_events.delete();
    if (!failed)
      if (parse_byte(b) && !failed) void'(parse_byte(b));
    if (last) begin
      len = offset + 1;
      if (!failed) begin
        if ((phase == P_N3 || phase == P_N5 || phase == P_N6 || phase == P_N9) &&
            nest_cnt == 0) begin
          close_token(VK_NUMBER, tok_start, len);
          add_event(EV_END, VK_STRING, 0, 0, '0, len, ERR_NONE);
        end else if (phase == P_DONE) begin
          add_event(EV_END, VK_STRING, 0, 0, '0, len, ERR_NONE);
        end else begin
          add_event(EV_ERROR, VK_STRING, 0, 0, len, '0, ERR_SHORT);
        end
      end
      clear_parser();
    end else begin
      offset = offset + 1;
    end
    if (byte_events.size() > 0) byte_events[$].run_last = 1'b1;
  endfunction

  task automatic send_beat(bit [7:0] b, bit last, bit typed, res_t want);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_events(b, last);
    if (typed) pending_events.push_back(want);
    else foreach (byte_events[i]) pending_events.push_back(byte_events[i]);
  endtask

  task automatic send_text();
    res_t none;
    none = '0;
    foreach (txt[i]) send_beat(txt[i], i == txt.size() - 1, 0, none);
    txt.delete();
  endtask

  function automatic void put_str(string s);
    foreach (s[i]) txt.push_back(s[i]);
  endfunction

  function automatic void gen_ws();
    bit [7:0] w[4] = '{" ", 8'h09, 8'h0a, 8'h0d};
    repeat ($urandom_range(0, 1)) txt.push_back(w[$urandom_range(0, 3)]);
  endfunction

  function automatic void gen_string();
    int n;
    n = $urandom_range(0, 4);
    txt.push_back("\"");
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: txt.push_back(8'h80 + 8'($urandom_range(0, 127)));
        1: begin
          bit [7:0] e[8] = '{"\"", "f", "/", "b", "n", "r", "t", "\\"};
          txt.push_back("\\");
          txt.push_back(e[$urandom_range(0, 7)]);
        end
        2: begin
          bit [7:0] h[22] = '{"0","1","2","3","4","5","6","7","8","9",
                              "a","b","c","d","e","f","A","B","C","D","E","F"};
          put_str("\\u");
          repeat (4) txt.push_back(h[$urandom_range(0, 21)]);
        end
        default: begin
          bit [7:0] c;
          c = 8'($urandom_range(32, 126));
          if (c == "\"" || c == "\\") c = "x";
          txt.push_back(c);
        end
      endcase
    end
    txt.push_back("\"");
  endfunction

  function automatic void gen_number();
    if ($urandom_range(0, 2) == 0) txt.push_back("-");
    if ($urandom_range(0, 3) == 0) txt.push_back("0");
    else begin
      txt.push_back(8'($urandom_range("1", "9")));
      repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 2) == 0) begin
      txt.push_back(".");
      repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 2) == 0) begin
      txt.push_back($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: txt.push_back("+");
        1: txt.push_back("-");
        default: ;
      endcase
      repeat ($urandom_range(1, 2)) txt.push_back(8'($urandom_range("0", "9")));
    end
  endfunction

  function automatic void gen_value(int lvl);
    int n;
    gen_ws();
    case ($urandom_range(0, (lvl < 3) ? 6 : 4))
      0: gen_string();
      1: gen_number();
      2: put_str("true");
      3: put_str("false");
      4: put_str("null");
      5: begin
        n = $urandom_range(0, 3);
        txt.push_back("{");
        for (int i = 0; i < n; i++) begin
          if (i > 0) txt.push_back(",");
          gen_ws(); gen_string(); gen_ws(); txt.push_back(":");
          gen_value(lvl + 1);
        end
        gen_ws();
        txt.push_back("}");
      end
      default: begin
        n = $urandom_range(0, 3);
        txt.push_back("[");
        for (int i = 0; i < n; i++) begin
          if (i > 0) txt.push_back(",");
          gen_value(lvl + 1);
        end
        gen_ws();
        txt.push_back("]");
      end
    endcase
    gen_ws();
  endfunction

  function automatic void add_row(bit [7:0] b, bit last, bit typed = 0, res_t want = '0);
    row_t r;
    r.b = b; r.last = last; r.typed = typed; r.want = want;
    rows.push_back(r);
  endfunction

  // result sink and checker
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.event_kind = out_ch.event_kind; got.value_kind = out_ch.value_kind;
      got.is_key = out_ch.is_key; got.nest_depth = out_ch.nest_depth;
      got.span_start = out_ch.span_start; got.span_end = out_ch.span_end;
      got.error_code = out_ch.error_code; got.run_last = out_ch.run_last;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_events.pop_front();
        if (got.event_kind !== want.event_kind || got.value_kind !== want.value_kind ||
            got.is_key !== want.is_key || got.nest_depth !== want.nest_depth ||
            got.span_start !== want.span_start || got.span_end !== want.span_end ||
            got.error_code !== want.error_code || got.run_last !== want.run_last) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
    out_ch.ready <= quiet || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    quiet <= (cycles >= 200 && cycles < 450);
    if (cycles > 100000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int sent;
    string s;
    mismatches = 0;
    cycles = 0;
    quiet = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.text_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    clear_parser();

    // bad first byte, then silence until the last byte
    add_row("x", 0, 1, res_t'{EV_ERROR, VK_STRING, 1'b0, 6'd0, 32'd0, 32'd0, ERR_BYTE, 1'b1});
    add_row("1", 0);
    add_row("]", 1);
    // empty array, then trailing junk on the last byte
    add_row("[", 0, 1, res_t'{EV_OPEN, VK_ARRAY, 1'b0, 6'd0, 32'd0, 32'd0, ERR_NONE, 1'b1});
    add_row("]", 0);
    add_row("\"", 1, 1, res_t'{EV_ERROR, VK_STRING, 1'b0, 6'd0, 32'd2, 32'd0, ERR_BYTE, 1'b1});
    // object with escapes, unicode and a number ended by the closing brace
    s = "{\"\\u0AfF\":-0.5e+7";
    foreach (s[i]) add_row(s[i], 0);
    add_row("}", 1);
    // incomplete true
    add_row("t", 1);
    // all-ones byte at the root
    add_row(8'hff, 1, 1, res_t'{EV_ERROR, VK_STRING, 1'b0, 6'd0, 32'd0, 32'd0, ERR_BYTE, 1'b1});
    // control byte inside a string
    add_row("\"", 0);
    add_row(8'h00, 0, 1, res_t'{EV_ERROR, VK_STRING, 1'b0, 6'd0, 32'd1, 32'd0, ERR_BYTE, 1'b1});
    add_row(" ", 1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_beat(rows[i].b, rows[i].last, rows[i].typed, rows[i].want);

    sent = 0;
    for (int t = 0; sent < 350; t++) begin
      if (t == 6) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0: begin
          // nesting just below, at and beyond the stack limit
          repeat ($urandom_range(MaxNest - 1, MaxNest + 2)) txt.push_back("[");
          if ($urandom_range(0, 1)) txt.push_back("1");
        end
        1: repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
        default: gen_value(0);
      endcase
      if ($urandom_range(0, 4) == 0 && txt.size() > 1) begin
        if ($urandom_range(0, 1)) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
        else txt = txt[0:$urandom_range(0, txt.size() - 2)];
      end
      sent += txt.size();
      send_text();
    end
    in_ch.valid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
